### design/ek_pkg.sv
// ek_pkg: shared types and constants for the max-flow engine
// depends on nothing; used by ek_matrix, the core and ek_checker
package ek_pkg;

    // default sizes for the top level parameters
    localparam int MAX_NODES_DEF = 256;
    localparam int CAP_WIDTH_DEF = 16;

    // fixed field widths
    localparam int FLOW_W    = 24;
    localparam int EPOCH_W   = 6;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 9;

    localparam logic [31:0]       BOT_INIT = 32'h7FFF_FFFF;
    localparam logic [FLOW_W-1:0] FLOW_MAX = {FLOW_W{1'b1}};

    // input word operation codes
    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_CLEAR = 2'd1,
        OP_RUN   = 2'd2,
        OP_NOP   = 2'd3
    } ek_op_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NODE_COUNT = 2'd0,
        CFG_SOURCE     = 2'd1,
        CFG_SINK       = 2'd2
    } ek_cfg_t;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_BFS_INIT,
        S_DEQ,
        S_LOAD_U,
        S_SCAN_RD,
        S_SCAN_EV,
        S_BOT_RD,
        S_BOT_U,
        S_BOT_EV,
        S_AUG_RD,
        S_AUG_U,
        S_AUG_EV,
        S_DONE
    } ek_state_t;

    // requests from the sequencer to the matrix store
    typedef struct packed {
        logic cap_clear;
        logic flow_clear;
    } ek_mat_cmd_t;

endpackage

### design/ek_alu.sv
// ek_alu: the one shared add/subtract and compare unit of the engine
// depends on nothing
module ek_alu #(
    parameter int RW = 34
) (
    input  logic signed [RW-1:0] a,
    input  logic signed [RW-1:0] b,
    input  logic signed [RW-1:0] c,
    input  logic signed [RW-1:0] d,
    output logic signed [RW-1:0] res,
    output logic                 pos,
    output logic                 lt
);

    // a - b + c, sign and compare against d
    always_comb
    begin
        res = a - b + c;
        pos = (res > 0);
        lt  = (res < d);
    end

endmodule

### design/ek_matrix.sv
// ek_matrix: capacity and flow matrices with epoch tags and clearing sweep
// depends on ek_pkg
module ek_matrix
    import ek_pkg::*;
#(
    parameter int NW    = 8,
    parameter int CAP_W = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ek_mat_cmd_t          cmd,
    output logic                 busy,
    input  logic [2*NW-1:0]      rd_addr_a,
    input  logic [2*NW-1:0]      rd_addr_b,
    output logic [CAP_W-1:0]     cap_a,
    output logic [FLOW_W-1:0]    flow_a,
    output logic [FLOW_W-1:0]    flow_b,
    input  logic                 cap_we,
    input  logic [2*NW-1:0]      cap_waddr,
    input  logic [CAP_W-1:0]     cap_wdata,
    input  logic                 flow_we,
    input  logic [2*NW-1:0]      flow_waddr,
    input  logic [FLOW_W-1:0]    flow_wdata
);

    localparam int AW    = 2 * NW;
    localparam int DEPTH = 1 << AW;
    localparam logic [EPOCH_W-1:0] EPOCH_TOP = {EPOCH_W{1'b1}};
    localparam logic [EPOCH_W-1:0] EPOCH_ONE = EPOCH_W'(1);

    logic [EPOCH_W+CAP_W-1:0]  cap_mem  [DEPTH];
    logic [EPOCH_W+FLOW_W-1:0] flow_mem [DEPTH];

    logic [EPOCH_W+CAP_W-1:0]  cap_q;
    logic [EPOCH_W+FLOW_W-1:0] flow_qa;
    logic [EPOCH_W+FLOW_W-1:0] flow_qb;

    logic [EPOCH_W-1:0] cap_epoch_reg, cap_epoch_next;
    logic [EPOCH_W-1:0] flow_epoch_reg, flow_epoch_next;
    logic               sweep_cap_reg, sweep_cap_next;
    logic               sweep_flow_reg, sweep_flow_next;
    logic [AW-1:0]      sweep_addr_reg, sweep_addr_next;

    // capacity memory: sweep zeroes tags, otherwise word writes
    always_ff @(posedge clk)
    begin
        if (sweep_cap_reg)
        begin
            cap_mem[sweep_addr_reg] <= '0;
        end
        else if (cap_we)
        begin
            cap_mem[cap_waddr] <= {cap_epoch_reg, cap_wdata};
        end
        cap_q <= cap_mem[rd_addr_a];
    end

    // flow memory: one write port, two read ports
    always_ff @(posedge clk)
    begin
        if (sweep_flow_reg)
        begin
            flow_mem[sweep_addr_reg] <= '0;
        end
        else if (flow_we)
        begin
            flow_mem[flow_waddr] <= {flow_epoch_reg, flow_wdata};
        end
        flow_qa <= flow_mem[rd_addr_a];
        flow_qb <= flow_mem[rd_addr_b];
    end

    // stale tags read as zero
    always_comb
    begin
        cap_a  = (cap_q[EPOCH_W+CAP_W-1:CAP_W] == cap_epoch_reg) ?
                 cap_q[CAP_W-1:0] : '0;
        flow_a = (flow_qa[EPOCH_W+FLOW_W-1:FLOW_W] == flow_epoch_reg) ?
                 flow_qa[FLOW_W-1:0] : '0;
        flow_b = (flow_qb[EPOCH_W+FLOW_W-1:FLOW_W] == flow_epoch_reg) ?
                 flow_qb[FLOW_W-1:0] : '0;
    end

    assign busy = sweep_cap_reg | sweep_flow_reg;

    // epoch advance, sweep on wrap
    always_comb
    begin
        cap_epoch_next  = cap_epoch_reg;
        flow_epoch_next = flow_epoch_reg;
        sweep_cap_next  = sweep_cap_reg;
        sweep_flow_next = sweep_flow_reg;
        sweep_addr_next = sweep_addr_reg;
        if (busy)
        begin
            sweep_addr_next = sweep_addr_reg + AW'(1);
            if (sweep_addr_reg == {AW{1'b1}})
            begin
                sweep_cap_next  = 1'b0;
                sweep_flow_next = 1'b0;
            end
        end
        else
        begin
            if (cmd.cap_clear)
            begin
                if (cap_epoch_reg == EPOCH_TOP)
                begin
                    cap_epoch_next = EPOCH_ONE;
                    sweep_cap_next = 1'b1;
                end
                else
                begin
                    cap_epoch_next = cap_epoch_reg + EPOCH_ONE;
                end
            end
            if (cmd.flow_clear)
            begin
                if (flow_epoch_reg == EPOCH_TOP)
                begin
                    flow_epoch_next = EPOCH_ONE;
                    sweep_flow_next = 1'b1;
                end
                else
                begin
                    flow_epoch_next = flow_epoch_reg + EPOCH_ONE;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_epoch_reg  <= EPOCH_ONE;
            flow_epoch_reg <= EPOCH_ONE;
            sweep_cap_reg  <= 1'b1;
            sweep_flow_reg <= 1'b1;
            sweep_addr_reg <= '0;
        end
        else
        begin
            cap_epoch_reg  <= cap_epoch_next;
            flow_epoch_reg <= flow_epoch_next;
            sweep_cap_reg  <= sweep_cap_next;
            sweep_flow_reg <= sweep_flow_next;
            sweep_addr_reg <= sweep_addr_next;
        end
    end

endmodule

### design/ek_bfs_mem.sv
// ek_bfs_mem: search queue and predecessor stores of the breadth-first search
// depends on nothing
module ek_bfs_mem #(
    parameter int NW = 8
) (
    input  logic          clk,
    input  logic          q_we,
    input  logic [NW-1:0] q_waddr,
    input  logic [NW-1:0] q_wdata,
    input  logic [NW-1:0] q_raddr,
    output logic [NW-1:0] q_rdata,
    input  logic          p_we,
    input  logic [NW-1:0] p_waddr,
    input  logic [NW-1:0] p_wdata,
    input  logic [NW-1:0] p_raddr,
    output logic [NW-1:0] p_rdata
);

    localparam int DEPTH = 1 << NW;

    logic [NW-1:0] queue_mem [DEPTH];
    logic [NW-1:0] pred_mem  [DEPTH];

    // queue: write at tail, registered read at head
    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            queue_mem[q_waddr] <= q_wdata;
        end
        q_rdata <= queue_mem[q_raddr];
    end

    // predecessor: write on discovery, registered read on path walk
    always_ff @(posedge clk)
    begin
        if (p_we)
        begin
            pred_mem[p_waddr] <= p_wdata;
        end
        p_rdata <= pred_mem[p_raddr];
    end

endmodule

### design/max_flow_bfs_augment_core.sv
// Edmonds-Karp maximum flow engine on a dense capacity matrix. A capacity
// write (op 0) or a capacity clear (op 1) is taken while idle. A run (op 2)
// holds in_ready low until max_flow is placed in the output register: each
// breadth-first search reads, for every node taken from the queue, the
// residual to every node in use from the matrix memories and evaluates it in
// the one shared adder; each augmenting path then adds a bottleneck walk and
// an update walk from the sink back to the source. A run with bad terminals
// goes straight to the result. After reset the matrix memories are swept one
// entry a cycle, as is the capacity memory after every 63rd clear and the
// flow memory after every 63rd run; no word is accepted then.
// depends on ek_pkg, ek_alu, ek_matrix, ek_bfs_mem
module max_flow_bfs_augment_core
    import ek_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF,
    parameter int CAP_WIDTH = CAP_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           op,
    input  logic [7:0]           from_node,
    input  logic [7:0]           to_node,
    input  logic [15:0]          capacity,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [FLOW_W-1:0]    max_flow,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    localparam int NW = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
    localparam int CW = $clog2(MAX_NODES + 1);
    localparam int WW = (CW > 9) ? CW : 9;
    localparam int RW = ((CAP_WIDTH > FLOW_W) ? CAP_WIDTH : FLOW_W) + 2;
    localparam logic [RW-1:0] BOT_START = (RW >= 32) ? RW'(BOT_INIT) :
                                          ((RW'(1) << (RW - 1)) - RW'(1));
    localparam logic [WW-1:0] MAX_W = WW'(MAX_NODES);

    ek_state_t state_reg, state_next;

    logic [8:0]           node_count_reg, node_count_next;
    logic [7:0]           source_reg, source_next;
    logic [7:0]           sink_reg, sink_next;

    logic [CW-1:0]        n_reg, n_next;
    logic [NW-1:0]        s_reg, s_next;
    logic [NW-1:0]        t_reg, t_next;
    logic [CW-1:0]        head_reg, head_next;
    logic [CW-1:0]        tail_reg, tail_next;
    logic [CW-1:0]        v_reg, v_next;
    logic [NW-1:0]        u_reg, u_next;
    logic [NW-1:0]        pv_reg, pv_next;
    logic [CW-1:0]        steps_reg, steps_next;
    logic                 found_reg, found_next;
    logic [MAX_NODES-1:0] visited_reg, visited_next;
    logic signed [RW-1:0] bot_reg, bot_next;
    logic signed [RW-1:0] total_reg, total_next;
    logic                 out_valid_reg, out_valid_next;
    logic [FLOW_W-1:0]    max_flow_reg, max_flow_next;

    // matrix store signals
    ek_mat_cmd_t          mat_cmd;
    logic                 mat_busy;
    logic [2*NW-1:0]      rd_addr_a, rd_addr_b;
    logic [CAP_WIDTH-1:0] cap_a;
    logic [FLOW_W-1:0]    flow_a, flow_b;
    logic                 cap_we, flow_we;
    logic [2*NW-1:0]      cap_waddr, flow_waddr;
    logic [CAP_WIDTH-1:0] cap_wdata;
    logic [FLOW_W-1:0]    flow_wdata;

    // search store signals
    logic                 q_we, p_we;
    logic [NW-1:0]        q_waddr, q_wdata, q_raddr, q_rdata;
    logic [NW-1:0]        p_waddr, p_wdata, p_raddr, p_rdata;

    // shared unit
    logic signed [RW-1:0] alu_a, alu_b, alu_c, alu_d, alu_res;
    logic                 alu_pos, alu_lt;

    // terminal checks at run start
    logic [WW-1:0]        n_clamp, s_w, t_w;
    logic                 bad_terms;

    ek_matrix #(
        .NW    (NW),
        .CAP_W (CAP_WIDTH)
    ) u_matrix (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (mat_cmd),
        .busy       (mat_busy),
        .rd_addr_a  (rd_addr_a),
        .rd_addr_b  (rd_addr_b),
        .cap_a      (cap_a),
        .flow_a     (flow_a),
        .flow_b     (flow_b),
        .cap_we     (cap_we),
        .cap_waddr  (cap_waddr),
        .cap_wdata  (cap_wdata),
        .flow_we    (flow_we),
        .flow_waddr (flow_waddr),
        .flow_wdata (flow_wdata)
    );

    ek_bfs_mem #(
        .NW (NW)
    ) u_bfs_mem (
        .clk     (clk),
        .q_we    (q_we),
        .q_waddr (q_waddr),
        .q_wdata (q_wdata),
        .q_raddr (q_raddr),
        .q_rdata (q_rdata),
        .p_we    (p_we),
        .p_waddr (p_waddr),
        .p_wdata (p_wdata),
        .p_raddr (p_raddr),
        .p_rdata (p_rdata)
    );

    ek_alu #(
        .RW (RW)
    ) u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .c   (alu_c),
        .d   (alu_d),
        .res (alu_res),
        .pos (alu_pos),
        .lt  (alu_lt)
    );

    assign in_ready  = (state_reg == S_IDLE) && !mat_busy;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign max_flow  = max_flow_reg;

    // node count clamp and terminal checks
    always_comb
    begin
        n_clamp   = (WW'(node_count_reg) > MAX_W) ? MAX_W : WW'(node_count_reg);
        s_w       = WW'(source_reg);
        t_w       = WW'(sink_reg);
        bad_terms = (s_w >= n_clamp) || (t_w >= n_clamp) || (s_w == t_w);
    end

    // configuration writes
    always_comb
    begin
        node_count_next = node_count_reg;
        source_next     = source_reg;
        sink_next       = sink_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_NODE_COUNT: node_count_next = cfg_data;
                CFG_SOURCE:     source_next     = cfg_data[7:0];
                CFG_SINK:       sink_next       = cfg_data[7:0];
                default:        ;
            endcase
        end
    end

    // sequencer: next state, memory and unit control
    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        s_next         = s_reg;
        t_next         = t_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        v_next         = v_reg;
        u_next         = u_reg;
        pv_next        = pv_reg;
        steps_next     = steps_reg;
        found_next     = found_reg;
        visited_next   = visited_reg;
        bot_next       = bot_reg;
        total_next     = total_reg;
        out_valid_next = out_valid_reg;
        max_flow_next  = max_flow_reg;

        mat_cmd    = '0;
        rd_addr_a  = '0;
        rd_addr_b  = '0;
        cap_we     = 1'b0;
        cap_waddr  = {NW'(from_node), NW'(to_node)};
        cap_wdata  = CAP_WIDTH'(capacity);
        flow_we    = 1'b0;
        flow_waddr = {p_rdata, pv_reg};
        flow_wdata = '0;
        q_we       = 1'b0;
        q_waddr    = tail_reg[NW-1:0];
        q_wdata    = v_reg[NW-1:0];
        q_raddr    = head_reg[NW-1:0];
        p_we       = 1'b0;
        p_waddr    = v_reg[NW-1:0];
        p_wdata    = u_reg;
        p_raddr    = pv_reg;

        // residual by default: cap(u,v) - flow(u,v) + flow(v,u)
        alu_a = RW'(cap_a);
        alu_b = RW'(flow_a);
        alu_c = RW'(flow_b);
        alu_d = bot_reg;

        // result leaves the output register
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    unique case (op)
                        OP_WRITE:
                        begin
                            cap_we = (WW'(from_node) < MAX_W) && (WW'(to_node) < MAX_W);
                        end
                        OP_CLEAR:
                        begin
                            mat_cmd.cap_clear = 1'b1;
                        end
                        OP_RUN:
                        begin
                            n_next     = CW'(n_clamp);
                            s_next     = NW'(source_reg);
                            t_next     = NW'(sink_reg);
                            total_next = '0;
                            state_next = bad_terms ? S_DONE : S_BFS_INIT;
                        end
                        OP_NOP: ;
                    endcase
                end
            end

            // start a search from the source
            S_BFS_INIT:
            begin
                visited_next        = '0;
                visited_next[s_reg] = 1'b1;
                q_we                = 1'b1;
                q_waddr             = '0;
                q_wdata             = s_reg;
                p_we                = 1'b1;
                p_waddr             = s_reg;
                p_wdata             = s_reg;
                head_next           = '0;
                tail_next           = CW'(1);
                found_next          = 1'b0;
                state_next          = S_DEQ;
            end

            S_DEQ:
            begin
                if ((head_reg < tail_reg) && !found_reg)
                begin
                    head_next  = head_reg + CW'(1);
                    state_next = S_LOAD_U;
                end
                else if (found_reg)
                begin
                    pv_next    = t_reg;
                    steps_next = '0;
                    bot_next   = BOT_START;
                    state_next = S_BOT_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_LOAD_U:
            begin
                u_next     = q_rdata;
                v_next     = '0;
                state_next = S_SCAN_RD;
            end

            S_SCAN_RD:
            begin
                rd_addr_a  = {u_reg, v_reg[NW-1:0]};
                rd_addr_b  = {v_reg[NW-1:0], u_reg};
                state_next = S_SCAN_EV;
            end

            // discover v if unvisited with spare residual
            S_SCAN_EV:
            begin
                if (!visited_reg[v_reg[NW-1:0]] && alu_pos &&
                    (tail_reg < CW'(MAX_NODES)))
                begin
                    visited_next[v_reg[NW-1:0]] = 1'b1;
                    p_we      = 1'b1;
                    q_we      = 1'b1;
                    tail_next = tail_reg + CW'(1);
                    if (v_reg[NW-1:0] == t_reg)
                    begin
                        found_next = 1'b1;
                    end
                end
                v_next     = v_reg + CW'(1);
                state_next = ((v_reg + CW'(1)) == n_reg) ? S_DEQ : S_SCAN_RD;
            end

            // bottleneck walk from sink back to source
            S_BOT_RD:
            begin
                if ((pv_reg == s_reg) || (steps_reg == n_reg))
                begin
                    pv_next    = t_reg;
                    steps_next = '0;
                    state_next = S_AUG_RD;
                end
                else
                begin
                    state_next = S_BOT_U;
                end
            end

            S_BOT_U:
            begin
                u_next     = p_rdata;
                rd_addr_a  = {p_rdata, pv_reg};
                rd_addr_b  = {pv_reg, p_rdata};
                state_next = S_BOT_EV;
            end

            S_BOT_EV:
            begin
                if (alu_lt)
                begin
                    bot_next = alu_res;
                end
                pv_next    = u_reg;
                steps_next = steps_reg + CW'(1);
                state_next = S_BOT_RD;
            end

            // flow update walk, then add bottleneck to the total
            S_AUG_RD:
            begin
                if ((pv_reg == s_reg) || (steps_reg == n_reg))
                begin
                    alu_a      = total_reg;
                    alu_b      = '0;
                    alu_c      = bot_reg;
                    total_next = alu_res;
                    state_next = S_BFS_INIT;
                end
                else
                begin
                    state_next = S_AUG_U;
                end
            end

            S_AUG_U:
            begin
                u_next     = p_rdata;
                rd_addr_a  = {p_rdata, pv_reg};
                rd_addr_b  = {pv_reg, p_rdata};
                state_next = S_AUG_EV;
            end

            S_AUG_EV:
            begin
                alu_a      = RW'(flow_a);
                alu_b      = '0;
                alu_c      = bot_reg;
                flow_we    = 1'b1;
                flow_waddr = {u_reg, pv_reg};
                flow_wdata = alu_res[FLOW_W-1:0];
                pv_next    = u_reg;
                steps_next = steps_reg + CW'(1);
                state_next = S_AUG_RD;
            end

            // hand over the result once the output register is free
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next     = 1'b1;
                    max_flow_next      = (total_reg > RW'(FLOW_MAX)) ?
                                         FLOW_MAX : total_reg[FLOW_W-1:0];
                    mat_cmd.flow_clear = 1'b1;
                    state_next         = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            node_count_reg <= 9'd2;
            source_reg     <= 8'd0;
            sink_reg       <= 8'd1;
            found_reg      <= 1'b0;
            visited_reg    <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            node_count_reg <= node_count_next;
            source_reg     <= source_next;
            sink_reg       <= sink_next;
            found_reg      <= found_next;
            visited_reg    <= visited_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        s_reg        <= s_next;
        t_reg        <= t_next;
        v_reg        <= v_next;
        u_reg        <= u_next;
        pv_reg       <= pv_next;
        steps_reg    <= steps_next;
        bot_reg      <= bot_next;
        total_reg    <= total_next;
        max_flow_reg <= max_flow_next;
    end

endmodule

### design/ek_checker.sv
// ek_checker: port-level checks of the max-flow engine, bound to the top level
// depends on ek_pkg and max_flow_bfs_augment_core
module ek_checker
    import ek_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic [1:0]           op,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [FLOW_W-1:0]    max_flow
);

    // a waiting result holds its word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(max_flow))
        else $error("result word changed while stalled");

    // writes and clears never produce a result
    a_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (op != OP_RUN) |=> !$rose(out_valid))
        else $error("result after a non-run word");

    // a run blocks the input side
    a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (op == OP_RUN) |=> !in_ready)
        else $error("input accepted during a run");

    // a result only follows a busy stretch
    a_result_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result without a run");

endmodule

bind max_flow_bfs_augment_core ek_checker u_ek_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .max_flow  (max_flow)
);
